// ===== rtl/bait_pkg.sv =====
// Shared widths, reset values, register addresses and interface types.
package bait_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int SUM_W       = 20;
  localparam int MEAN_W      = 12;
  localparam int COEF_W      = 16;
  localparam int TEMP_W      = 20;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int BATCH_DEF   = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COEF_W-1:0] ALPHA_RESET = 16'd3277;
  localparam logic [COEF_W-1:0] SCALE_RESET = 16'd5282;

  // register select bit of paddr: 0 = smoothing_alpha, 1 = raw_to_degrees_scale
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  typedef struct packed {
    logic             push;
    logic [SUM_W-1:0] sum;
  } batch_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ===== rtl/bait_front.sv =====
// Front end: accepts samples, accumulates a batch and queues the batch sum.
module bait_front import bait_pkg::*; #(
  parameter int BATCH = BATCH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [SAMPLE_W-1:0] adc_sample,
  input  queue_status_t       qstat,
  output batch_push_t         qpush
);

  localparam int CNT_W = $clog2(BATCH + 1);

  logic [CNT_W-1:0] sample_count;
  logic [SUM_W-1:0] sample_sum;
  logic [SUM_W-1:0] sum_next;
  logic             accept;
  logic             last;

  assign sample_stall = qstat.full;
  assign accept       = sample_valid && !qstat.full;
  assign last         = (sample_count == CNT_W'(BATCH - 1));
  assign sum_next     = sample_sum + SUM_W'(adc_sample);

  assign qpush.push = accept && last;
  assign qpush.sum  = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      sample_sum   <= '0;
    end else if (accept) begin
      if (last) begin
        sample_count <= '0;
        sample_sum   <= '0;
      end else begin
        sample_count <= sample_count + 1'b1;
        sample_sum   <= sum_next;
      end
    end
  end

endmodule

// ===== rtl/bait_queue.sv =====
// Short queue of batch sums between the front and the back end.
module bait_queue import bait_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  batch_push_t      qpush,
  input  logic             pop,
  output logic [SUM_W-1:0] pop_sum,
  output queue_status_t    qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [SUM_W-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign qstat.empty = (fill == '0);
  assign qstat.full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign do_push     = qpush.push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_sum     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= qpush.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/bait_back.sv =====
// Back end: divide a batch sum, scale to degrees, smooth unless history is zero, output.
module bait_back import bait_pkg::*; #(
  parameter int BATCH = BATCH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  queue_status_t     qstat,
  input  logic [SUM_W-1:0]  pop_sum,
  output logic              pop,
  input  logic [COEF_W-1:0] alpha,
  input  logic [COEF_W-1:0] scale,
  output logic              temperature_valid,
  input  logic              temperature_stall,
  output logic [TEMP_W-1:0] temperature_q8
);

  // floor(sum / BATCH) as (sum * RECIP) >> DIV_SHIFT, exact for any 20-bit sum
  localparam int    RECIP_W    = SUM_W + 1;
  localparam int    DIV_SHIFT  = SUM_W + $clog2(BATCH);
  localparam longint RECIP_FULL = ((longint'(1) << DIV_SHIFT) + longint'(BATCH) - 1)
                                  / longint'(BATCH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int    DPROD_W    = SUM_W + RECIP_W;
  localparam int    PNEW_W     = TEMP_W + COEF_W;
  localparam int    POLD_W     = TEMP_W + COEF_W + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CONV = 3'd2;
  localparam logic [2:0] ST_MNEW = 3'd3;
  localparam logic [2:0] ST_MOLD = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]               state;
  logic [SUM_W-1:0]         quot;
  logic [TEMP_W-1:0]        fresh;
  logic [TEMP_W-1:0]        result;
  logic [TEMP_W-1:0]        smoothed_temp;
  logic [PNEW_W-1:0]        p_new;
  logic [POLD_W-1:0]        p_old;

  logic [DPROD_W-1:0]       div_prod;
  logic [MEAN_W+COEF_W-1:0] conv_prod;
  logic [COEF_W:0]          weight_old;
  logic [POLD_W-1:0]        acc;
  logic                     out_free;

  assign div_prod   = quot * RECIP;
  assign conv_prod  = quot[MEAN_W-1:0] * scale;
  assign weight_old = (COEF_W + 1)'(1 << COEF_W) - {1'b0, alpha};
  assign acc        = {1'b0, p_new} + p_old;
  assign out_free   = !temperature_valid || !temperature_stall;
  assign pop        = (state == ST_IDLE) && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      smoothed_temp     <= '0;
      temperature_valid <= 1'b0;
    end else begin
      if ((state == ST_OUT) && out_free) begin
        temperature_valid <= 1'b1;
      end else if (temperature_valid && !temperature_stall) begin
        temperature_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!qstat.empty) begin
            quot  <= pop_sum;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          quot  <= SUM_W'(div_prod >> DIV_SHIFT);
          state <= ST_CONV;
        end
        ST_CONV: begin
          fresh  <= conv_prod[MEAN_W+COEF_W-1:8];
          result <= conv_prod[MEAN_W+COEF_W-1:8];
          state  <= (smoothed_temp == '0) ? ST_OUT : ST_MNEW;
        end
        ST_MNEW: begin
          p_new <= fresh * alpha;
          state <= ST_MOLD;
        end
        ST_MOLD: begin
          p_old <= smoothed_temp * weight_old;
          state <= ST_SUM;
        end
        ST_SUM: begin
          result <= acc[COEF_W+TEMP_W-1:COEF_W];
          state  <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            smoothed_temp  <= result;
            temperature_q8 <= result;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/batch_average_iir_temperature_core.sv =====
// Top level: configuration registers, front end, batch queue and back end.
//
// Samples enter on adc_sample with sample_valid/sample_stall; an item is
// taken at a clock edge with valid high and stall low. One item a cycle is
// taken while the batch queue has room. Every BATCH samples the batch sum
// is queued; the back end divides it by BATCH with one reciprocal multiply,
// converts it with one multiply and blends it with two more. A result
// shows on temperature_q8 with temperature_valid once the back end has
// passed its divide, convert, blend and output states; the blend states
// are skipped while the smoothed value is still zero. The back end takes
// a batch at a time, popping when idle. When the receiver stalls, the
// result holds in the output register, the back end waits and, once the
// queue fills, sample_stall rises. Synchronous reset clears the batch sum,
// count, queue, smoothed value and output valid, and loads the default
// alpha and scale. Registers: alpha at 0x0, scale at 0x4 (APB, no wait).
module batch_average_iir_temperature_core import bait_pkg::*; #(
  parameter int BATCH = BATCH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [SAMPLE_W-1:0] adc_sample,
  output logic                temperature_valid,
  input  logic                temperature_stall,
  output logic [TEMP_W-1:0]   temperature_q8
);

  logic [COEF_W-1:0] smoothing_alpha;
  logic [COEF_W-1:0] raw_to_degrees_scale;
  logic              wr_en;
  logic              reg_sel;
  batch_push_t       qpush;
  queue_status_t     qstat;
  logic [SUM_W-1:0]  pop_sum;
  logic              pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_SCALE) ? DATA_W'(raw_to_degrees_scale)
                                          : DATA_W'(smoothing_alpha);

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_alpha      <= ALPHA_RESET;
      raw_to_degrees_scale <= SCALE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ALPHA: smoothing_alpha      <= pwdata[COEF_W-1:0];
        REG_SCALE: raw_to_degrees_scale <= pwdata[COEF_W-1:0];
        default:   smoothing_alpha      <= smoothing_alpha;
      endcase
    end
  end

  bait_front #(.BATCH(BATCH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .adc_sample   (adc_sample),
    .qstat        (qstat),
    .qpush        (qpush)
  );

  bait_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .qpush   (qpush),
    .pop     (pop),
    .pop_sum (pop_sum),
    .qstat   (qstat)
  );

  bait_back #(.BATCH(BATCH)) u_back (
    .clk               (clk),
    .rst               (rst),
    .qstat             (qstat),
    .pop_sum           (pop_sum),
    .pop               (pop),
    .alpha             (smoothing_alpha),
    .scale             (raw_to_degrees_scale),
    .temperature_valid (temperature_valid),
    .temperature_stall (temperature_stall),
    .temperature_q8    (temperature_q8)
  );

endmodule

// ===== test/batch_average_iir_temperature_core_tb.sv =====
// Self-checking testbench for the batch-averaging temperature core.
`timescale 1ns / 1ps

module batch_average_iir_temperature_core_tb;
  import bait_pkg::*;

  localparam int BATCH       = BATCH_DEF;
  localparam int DRAIN_WAIT  = 40;
  localparam int QUIET_LIMIT = 5000;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 120;
  localparam logic [ADDR_W-1:0] ALPHA_ADDR = {REG_ALPHA, 2'b00};
  localparam logic [ADDR_W-1:0] SCALE_ADDR = {REG_SCALE, 2'b00};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  logic [SAMPLE_W-1:0] adc_sample = '0;
  logic                temperature_valid;
  logic                temperature_stall = 1'b0;
  logic [TEMP_W-1:0]   temperature_q8;

  batch_average_iir_temperature_core #(.BATCH(BATCH)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .adc_sample(adc_sample),
    .temperature_valid(temperature_valid), .temperature_stall(temperature_stall),
    .temperature_q8(temperature_q8)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [SUM_W-1:0]    batch_sum = '0;
  logic [7:0]          batch_count = '0;
  logic [TEMP_W-1:0]   smoothed_q8 = '0;
  logic [COEF_W-1:0]   alpha_q16 = ALPHA_RESET;
  logic [COEF_W-1:0]   scale_q16 = SCALE_RESET;

  logic [SAMPLE_W-1:0] pending_samples[$];
  logic [TEMP_W-1:0]   expected_temps[$];
  logic [TEMP_W-1:0]   want_temp;
  int                  samples_queued = 0;
  int                  samples_taken = 0;
  int                  temps_seen = 0;
  int                  errors = 0;
  int                  quiet_cycles = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;

  function automatic void absorb_sample(input logic [SAMPLE_W-1:0] s);
    logic [SUM_W-1:0]  mean;
    logic [63:0]       prod;
    logic [TEMP_W-1:0] fresh;
    begin
      batch_sum = batch_sum + SUM_W'(s);
      if (batch_count + 1 < BATCH) begin
        batch_count = batch_count + 8'd1;
      end else begin
        mean  = batch_sum / SUM_W'(BATCH);
        prod  = 64'(mean) * 64'(scale_q16);
        fresh = TEMP_W'(prod >> 8);
        if (smoothed_q8 == '0) begin
          smoothed_q8 = fresh;
        end else begin
          prod = 64'(fresh) * 64'(alpha_q16) + 64'(smoothed_q8) * (64'd65536 - 64'(alpha_q16));
          smoothed_q8 = TEMP_W'(prod >> 16);
        end
        batch_sum   = '0;
        batch_count = '0;
        expected_temps.push_back(smoothed_q8);
      end
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || !sample_stall) begin
      if (sample_valid) begin
        absorb_sample(adc_sample);
        samples_taken++;
      end
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_valid <= 1'b1;
        adc_sample   <= pending_samples.pop_front();
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      temperature_stall <= 1'b0;
    end else begin
      temperature_stall <= ($urandom_range(99) < recv_idle_pct);
      if (temperature_valid && !temperature_stall) begin
        temps_seen++;
        if (expected_temps.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected temperature item %0d", temperature_q8);
        end else begin
          want_temp = expected_temps.pop_front();
          if (temperature_q8 !== want_temp) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: temperature_q8 expected %0d got %0d", want_temp, temperature_q8);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (temperature_valid && !temperature_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic check_reg(input logic [ADDR_W-1:0] addr, input logic [COEF_W-1:0] want);
    logic [DATA_W-1:0] got;
    begin
      @(posedge clk);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
      @(posedge clk);
      penable <= 1'b1;
      @(negedge clk);
      got = prdata;
      @(posedge clk);
      psel <= 1'b0; penable <= 1'b0;
      if (got !== DATA_W'(want)) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: register 0x%0h read expected %0d got %0d", addr, want, got);
      end
    end
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [COEF_W-1:0] value);
    begin
      @(posedge clk);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
      pwdata <= {16'($urandom), value};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ALPHA_ADDR) alpha_q16 = value;
      else scale_q16 = value;
      check_reg(addr, value);
    end
  endtask

  task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
    begin
      pending_samples.push_back(s);
      samples_queued++;
    end
  endtask

  // one chunk of random stimulus, usually a whole batch, sometimes with some structure
  task automatic queue_chunk();
    int                  kind;
    int                  len;
    logic [SAMPLE_W-1:0] base;
    begin
      kind = $urandom_range(9);
      len  = (kind == 9) ? $urandom_range(1, 15) : BATCH;
      base = SAMPLE_W'($urandom);
      for (int i = 0; i < len; i++) begin
        case (kind)
          5: queue_sample(base);
          6: queue_sample($urandom_range(1) ? 12'hFFF : 12'h000);
          7: queue_sample(SAMPLE_W'($urandom_range(15)));
          8: queue_sample(base ^ SAMPLE_W'($urandom_range(7)));
          default: queue_sample(SAMPLE_W'($urandom));
        endcase
      end
    end
  endtask

  task automatic wait_drained();
    begin
      while (samples_taken != samples_queued || expected_temps.size() != 0) @(negedge clk);
      repeat (DRAIN_WAIT) @(negedge clk);
    end
  endtask

  logic [COEF_W-1:0] phase_alpha[NUM_PHASES];
  logic [COEF_W-1:0] phase_scale[NUM_PHASES];

  initial begin
    phase_alpha = '{16'd0, 16'd65535, 16'd65535, 16'd1, 16'($urandom), 16'd32768,
                    16'($urandom), ALPHA_RESET, 16'd0};
    phase_scale = '{16'd65535, 16'd0, 16'd65535, 16'd1, 16'($urandom), SCALE_RESET,
                    16'($urandom), SCALE_RESET, 16'd0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    check_reg(ALPHA_ADDR, ALPHA_RESET);
    check_reg(SCALE_ADDR, SCALE_RESET);

    // directed: all-zero batch keeps history empty, full-scale batch is taken
    // directly, then an alternating-bit batch blends, then a partial batch
    send_idle_pct = 34; recv_idle_pct = 53;
    for (int i = 0; i < BATCH; i++) queue_sample(12'h000);
    for (int i = 0; i < BATCH; i++) queue_sample(12'hFFF);
    for (int i = 0; i < BATCH; i++) queue_sample(i[0] ? 12'hAAA : 12'h555);
    for (int i = 0; i < 3; i++) queue_sample(12'h001);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin send_idle_pct = 34; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(ALPHA_ADDR, phase_alpha[p]);
      write_reg(SCALE_ADDR, phase_scale[p]);
      while (samples_queued < 33 + (p + 1) * PHASE_ITEMS) queue_chunk();
      wait_drained();
    end

    if (expected_temps.size() != 0) begin
      errors++;
      $display("ERROR: %0d temperature items never arrived", expected_temps.size());
    end
    $display("Ran %0d samples through %0d register settings, checked %0d temperatures.",
             samples_taken, NUM_PHASES + 1, temps_seen);
    $display("Mismatches: %0d", errors);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
